@@ src/swcg_pkg.sv @@
package swcg_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_WINDOW_KIND   = 3'd0,
      REG_PERIODIC_FORM = 3'd1,
      REG_WINDOW_LENGTH = 3'd2,
      REG_ALPHA_COEF    = 3'd3,
      REG_BETA_COEF     = 3'd4
   } csr_reg_type;

   // window kinds; codes two and three decode as Bartlett
   localparam logic [1:0] KIND_RAISED   = 2'd0;
   localparam logic [1:0] KIND_BLACKMAN = 2'd1;

   localparam int PHASE_BITS = 32;   // phase of a full turn, Q32
   localparam int DIV_STAGES = PHASE_BITS;
   localparam int COS_STAGES = 7;

   // quarter-cosine polynomial, Q30
   localparam logic [31:0] QK1 = 32'd1324675879;
   localparam logic [31:0] QK2 = 32'd272375560;
   localparam logic [31:0] QK3 = 32'd22401992;
   localparam logic [31:0] QK4 = 32'd987048;
   localparam logic [31:0] QK5 = 32'd27060;
   localparam logic [31:0] Q30_ONE = 32'h4000_0000;

   // Blackman weights: 0.42 and 0.08 in Q30
   localparam logic signed [63:0] BK_042 = 64'sd450971566;
   localparam logic signed [31:0] BK_008 = 32'sd85899346;

   typedef struct packed {
      logic       invalid;
      logic       one;
      logic [1:0] kind;
   } meta_type;

endpackage

@@ src/swcg_req_if.sv @@
interface swcg_req_if #(parameter int LENGTH_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic [LENGTH_BITS-1:0] sample_index;

   modport source (output valid, output sample_index, input ready);
   modport sink   (input valid, input sample_index, output ready);
endinterface

@@ src/swcg_rsp_if.sv @@
interface swcg_rsp_if #(parameter int COEF_WIDTH = 18);
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] coefficient;
   logic                         index_invalid;

   modport source (output valid, output coefficient, output index_invalid, input ready);
   modport sink   (input valid, input coefficient, input index_invalid, output ready);
endinterface

@@ src/spectral_window_coefficient_gen_top.sv @@
// Window coefficient generator (raised cosine / Blackman / Bartlett), signed Q2.F output.
// req_if carries a sample index; rsp_if returns the coefficient and an invalid flag.
// Write kind, periodic form, length, alpha and beta through the csr_ port while
// the block is idle; register i is index i, and unknown indexes are dropped.
// Throughput: one word per clock while rsp_if is not stalled. An accepted index passes
// through the index reduction stage, a 32-stage one-bit-per-stage phase divider,
// 7 cosine polynomial stages and two combine stages before rsp valid.
// The whole pipeline advances together: when rsp_if.ready is low while a result
// is shown, every stage holds and req_if.ready drops; nothing is lost or repeated.
// Reset (synchronous) empties the pipeline and restores Hamming defaults,
// periodic form, length zero.
module spectral_window_coefficient_gen_top #(
   parameter int LENGTH_BITS    = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   swcg_req_if.sink             req_if,
   swcg_rsp_if.source           rsp_if,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [((LENGTH_BITS > COEF_FRAC_BITS + 2) ?
                  LENGTH_BITS : COEF_FRAC_BITS + 2)-1:0] csr_wdata
);
   localparam int LB  = LENGTH_BITS;
   localparam int F   = COEF_FRAC_BITS;
   localparam int CW  = F + 2;
   localparam int ND  = swcg_pkg::DIV_STAGES + swcg_pkg::COS_STAGES;
   localparam int BSH = 31 - F;
   localparam logic [CW-1:0] ALPHA_RST = CW'(((64'd54 << F) + 64'd50) / 64'd100);
   localparam logic [CW-1:0] BETA_RST  = CW'(((64'd46 << F) + 64'd50) / 64'd100);
   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (F + 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

   // configuration
   logic [1:0]    kind_ff;
   logic          periodic_ff;
   logic [LB-1:0] len_ff;
   logic [CW-1:0] alpha_ff;
   logic [CW-1:0] beta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff     <= swcg_pkg::KIND_RAISED;
         periodic_ff <= 1'b1;
         len_ff      <= '0;
         alpha_ff    <= ALPHA_RST;
         beta_ff     <= BETA_RST;
      end else if (csr_we) begin
         unique case (swcg_pkg::csr_reg_type'(csr_index))
            swcg_pkg::REG_WINDOW_KIND:   kind_ff     <= csr_wdata[1:0];
            swcg_pkg::REG_PERIODIC_FORM: periodic_ff <= csr_wdata[0];
            swcg_pkg::REG_WINDOW_LENGTH: len_ff      <= csr_wdata[LB-1:0];
            swcg_pkg::REG_ALPHA_COEF:    alpha_ff    <= csr_wdata[CW-1:0];
            swcg_pkg::REG_BETA_COEF:     beta_ff     <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;
   assign en           = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   // stage 1: reduce index and twice index modulo the denominator, fold index about half, flag
   logic [LB-1:0] d_w;
   logic [LB-1:0] n_w;
   logic [LB-1:0] half_w;
   logic [LB:0]   t2_w;
   logic [LB:0]   t2a_w;
   logic [LB:0]   t2b_w;
   logic [LB-1:0] r1_in;
   logic [LB-1:0] m_in;
   swcg_pkg::meta_type meta_in;

   always_comb begin
      n_w    = req_if.sample_index;
      d_w    = periodic_ff ? len_ff : (len_ff - LB'(1));
      half_w = d_w >> 1;
      r1_in  = (n_w >= d_w) ? (n_w - d_w) : n_w;
      t2_w   = {n_w, 1'b0};
      t2a_w  = (t2_w >= {1'b0, d_w}) ? (t2_w - {1'b0, d_w}) : t2_w;
      t2b_w  = (t2a_w >= {1'b0, d_w}) ? (t2a_w - {1'b0, d_w}) : t2a_w;
      m_in   = (n_w <= half_w) ? n_w : (d_w - n_w);
      meta_in.invalid = (len_ff == '0) || (n_w >= len_ff);
      meta_in.one     = (len_ff == LB'(1));
      meta_in.kind    = kind_ff;
   end

   logic               s1_valid_ff;
   logic [LB-1:0]      s1_r1_ff;
   logic [LB-1:0]      s1_r2_ff;
   logic [LB-1:0]      s1_m_ff;
   logic [LB-1:0]      s1_half_ff;
   swcg_pkg::meta_type s1_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_r1_ff   <= r1_in;
         s1_r2_ff   <= t2b_w[LB-1:0];
         s1_m_ff    <= m_in;
         s1_half_ff <= half_w;
         s1_meta_ff <= meta_in;
      end
   end

   // divider operands; Bartlett is scaled up by 2^(31-F) so it shares the lane
   logic              bart_s1;
   logic [LB+30:0]    hs_w;
   logic [LB-1:0]     x1_w;
   logic [31:0]       l1_w;
   logic [31:0]       l2_w;

   always_comb begin
      bart_s1 = (s1_meta_ff.kind != swcg_pkg::KIND_RAISED) &&
                (s1_meta_ff.kind != swcg_pkg::KIND_BLACKMAN);
      hs_w    = (LB + 31)'(s1_half_ff) << BSH;
      l2_w    = 32'(s1_half_ff);
      if (bart_s1) begin
         x1_w = s1_m_ff + LB'(hs_w[LB+30:32]);
         l1_w = hs_w[31:0];
      end else begin
         x1_w = s1_r1_ff;
         l1_w = l2_w;
      end
   end

   logic [31:0]        q1_w;
   logic [31:0]        q2_w;
   logic signed [31:0] c1_w;
   logic signed [31:0] c2_w;

   swcg_div #(.LENGTH_BITS(LB)) u_div1 (
      .clock(clock), .en(en), .den(d_w), .x_in(x1_w), .low_in(l1_w), .quo(q1_w));
   swcg_div #(.LENGTH_BITS(LB)) u_div2 (
      .clock(clock), .en(en), .den(d_w), .x_in(s1_r2_ff), .low_in(l2_w), .quo(q2_w));
   swcg_cos u_cos1 (.clock(clock), .en(en), .phase(q1_w), .cos_val(c1_w));
   swcg_cos u_cos2 (.clock(clock), .en(en), .phase(q2_w), .cos_val(c2_w));

   // item tags travel beside the lanes
   logic               v_ff [ND];
   swcg_pkg::meta_type md_ff [ND];
   logic [31:0]        bq_ff [swcg_pkg::COS_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ND; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= s1_valid_ff;
         for (int i = 1; i < ND; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         md_ff[0] <= s1_meta_ff;
         for (int i = 1; i < ND; i++) begin
            md_ff[i] <= md_ff[i-1];
         end
         bq_ff[0] <= q1_w;
         for (int i = 1; i < swcg_pkg::COS_STAGES; i++) begin
            bq_ff[i] <= bq_ff[i-1];
         end
      end
   end

   // combine stage: products
   logic                   m_valid_ff;
   swcg_pkg::meta_type     m_meta_ff;
   logic signed [CW+31:0]  bc_ff;
   logic signed [63:0]     k8_ff;
   logic signed [31:0]     mc1_ff;
   logic [31:0]            mbq_ff;
   logic signed [63:0]     k8_w;

   assign k8_w = swcg_pkg::BK_008 * c2_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= v_ff[ND-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_meta_ff <= md_ff[ND-1];
         bc_ff     <= $signed(beta_ff) * c1_w;
         k8_ff     <= k8_w;
         mc1_ff    <= c1_w;
         mbq_ff    <= bq_ff[swcg_pkg::COS_STAGES-1];
      end
   end

   // final stage: round, select, saturate, zero invalid words
   logic signed [63:0] rc_w;
   logic signed [63:0] bk_v;
   logic signed [63:0] bk_w;
   logic signed [63:0] bt_w;
   logic signed [63:0] sel_w;
   logic signed [63:0] sat_w;

   always_comb begin
      rc_w = 64'($signed(alpha_ff)) +
             (((64'sd1 <<< 29) - 64'(bc_ff)) >>> 30);
      bk_v = (swcg_pkg::BK_042 <<< 30) - (64'(mc1_ff) <<< 29) + k8_ff;
      bk_w = (bk_v + (64'sd1 <<< (59 - F))) >>> (60 - F);
      bt_w = $signed({32'd0, mbq_ff >> BSH});
      if (m_meta_ff.one) begin
         sel_w = 64'sd1 <<< F;
      end else if (m_meta_ff.kind == swcg_pkg::KIND_RAISED) begin
         sel_w = rc_w;
      end else if (m_meta_ff.kind == swcg_pkg::KIND_BLACKMAN) begin
         sel_w = bk_w;
      end else begin
         sel_w = bt_w;
      end
      if (m_meta_ff.invalid) begin
         sat_w = '0;
      end else if (sel_w > SAT_HI) begin
         sat_w = SAT_HI;
      end else if (sel_w < SAT_LO) begin
         sat_w = SAT_LO;
      end else begin
         sat_w = sel_w;
      end
   end

   logic [CW-1:0] coef_ff;
   logic          inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coef_ff <= sat_w[CW-1:0];
         inv_ff  <= m_meta_ff.invalid;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.coefficient   = $signed(coef_ff);
   assign rsp_if.index_invalid = inv_ff;
endmodule

@@ src/swcg_div.sv @@
// Restoring divider, one quotient bit per stage: quo = floor((x*2^32 + low) / den), x < den.
module swcg_div #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [LENGTH_BITS-1:0] den,
   input  logic [LENGTH_BITS-1:0] x_in,
   input  logic [31:0]            low_in,
   output logic [31:0]            quo
);
   localparam int N = swcg_pkg::DIV_STAGES;

   logic [LENGTH_BITS-1:0] rem_ff [N];
   logic [31:0]            low_ff [N];
   logic [31:0]            quo_ff [N];

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [LENGTH_BITS-1:0] rem_src;
      logic [31:0]            low_src;
      logic [31:0]            quo_src;
      logic [LENGTH_BITS:0]   shifted;
      logic [LENGTH_BITS:0]   diff;
      logic                   ge;
      logic [LENGTH_BITS-1:0] rem_in;
      logic [31:0]            low_in_s;
      logic [31:0]            quo_in;

      if (s == 0) begin : g_first
         assign rem_src = x_in;
         assign low_src = low_in;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign low_src = low_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      always_comb begin
         shifted  = {rem_src, low_src[31]};
         diff     = shifted - {1'b0, den};
         ge       = shifted >= {1'b0, den};
         rem_in   = ge ? diff[LENGTH_BITS-1:0] : shifted[LENGTH_BITS-1:0];
         low_in_s = {low_src[30:0], 1'b0};
         quo_in   = {quo_src[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            low_ff[s] <= low_in_s;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[N-1];
endmodule

@@ src/swcg_cos.sv @@
// Cosine of a Q32 turn fraction, Q30 result; at most one multiply per stage.
module swcg_cos (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        phase,
   output logic signed [31:0] cos_val
);
   logic [30:0]        x_ff;
   logic               neg_ff [6];
   logic [30:0]        u_ff [5];
   logic [31:0]        p_ff [4];
   logic signed [31:0] cos_ff;

   logic [30:0] t_w;
   logic [30:0] x_in;
   logic [61:0] sq_w;
   logic [30:0] u_in;
   logic [31:0] kh [4];

   always_comb begin
      kh[0] = swcg_pkg::QK4;
      kh[1] = swcg_pkg::QK3;
      kh[2] = swcg_pkg::QK2;
      kh[3] = swcg_pkg::QK1;
      t_w   = {1'b0, phase[29:0]};
      x_in  = phase[30] ? (swcg_pkg::Q30_ONE[30:0] - t_w) : t_w;
      sq_w  = x_ff * x_ff;
      u_in  = sq_w[60:30];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff      <= x_in;
         neg_ff[0] <= phase[31] ^ phase[30];
         u_ff[0]   <= u_in;
         neg_ff[1] <= neg_ff[0];
      end
   end

   // Horner steps
   for (genvar s = 0; s < 4; s++) begin : g_horner
      logic [31:0] p_src;
      logic [62:0] prod;
      logic [31:0] p_in;
      if (s == 0) begin : g_first
         assign p_src = swcg_pkg::QK5;
      end else begin : g_next
         assign p_src = p_ff[s-1];
      end
      always_comb begin
         prod = p_src * u_ff[s];
         p_in = kh[s] - prod[61:30];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[s]     <= p_in;
            u_ff[s+1]   <= u_ff[s];
            neg_ff[s+2] <= neg_ff[s+1];
         end
      end
   end

   logic [62:0]        last_prod;
   logic signed [33:0] r_w;
   logic signed [31:0] c_w;

   always_comb begin
      last_prod = p_ff[3] * u_ff[4];
      r_w = $signed({2'b00, swcg_pkg::Q30_ONE}) - $signed({2'b00, last_prod[61:30]});
      if (r_w < 0) begin
         c_w = '0;
      end else begin
         c_w = r_w[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= neg_ff[5] ? -c_w : c_w;
      end
   end

   assign cos_val = cos_ff;
endmodule

@@ src/swcg_checker.sv @@
module swcg_checker #(
   parameter int COEF_WIDTH = 18
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COEF_WIDTH-1:0] coefficient,
   input logic                  index_invalid
);
   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(coefficient) && $stable(index_invalid))
      else $error("stalled result word changed");

   // invalid index always carries a zero coefficient
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && index_invalid |-> coefficient == '0)
      else $error("invalid word with nonzero coefficient");

   // input is only held off while the output is stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !rsp_ready) |-> req_ready)
      else $error("request stalled without output back-pressure");

   // hold the input off while the output is stalled
   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while output stalled");
endmodule

bind spectral_window_coefficient_gen_top swcg_checker #(
   .COEF_WIDTH(COEF_FRAC_BITS + 2)
) u_swcg_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .coefficient(rsp_if.coefficient),
   .index_invalid(rsp_if.index_invalid)
);
